>>> design/dlfc_pkg.sv
// shared types, constants and the crc update for the dnp3 link frame checker
package dlfc_pkg;

  localparam int unsigned BLOCK_BYTES    = 16;
  localparam int unsigned MAX_USER_BYTES = 250;
  localparam int unsigned FILL_W         = $clog2(BLOCK_BYTES + 1);

  localparam logic [7:0]  START_LO   = 8'h05;
  localparam logic [7:0]  START_HI   = 8'h64;
  localparam logic [7:0]  MIN_LEN    = 8'd5;
  localparam logic [15:0] CRC_POLY   = 16'hA6BC;
  localparam logic [15:0] CRC_XOROUT = 16'hFFFF;
  localparam logic [7:0]  CAP_RESET  = 8'd250;

  localparam logic KIND_USER = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_START  = 3'd1,
    ST_SHORT_LEN  = 3'd2,
    ST_HEADER_CRC = 3'd3,
    ST_CAPACITY   = 3'd4,
    ST_TRUNCATED  = 3'd5,
    ST_BLOCK_CRC  = 3'd6
  } status_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  user_byte;
    status_e     status;
    logic [7:0]  control_octet;
    logic [15:0] destination;
    logic [15:0] source;
    logic [7:0]  length_octet;
    logic [7:0]  user_count;
  } out_item_t;

  // item handed from one stage to the next
  typedef struct packed {
    logic     valid;
    in_item_t data;
  } in_xfer_t;

  typedef struct packed {
    logic      push;
    out_item_t data;
  } out_xfer_t;

  // one octet through the reflected crc-16/dnp shift register
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] octet);
    logic [15:0] c;
    c = crc ^ {8'h00, octet};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> design/dlfc_in_reg.sv
// input register that holds one received octet until the result queue has room
module dlfc_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dlfc_pkg::in_item_t in_data_i,
  input  logic               full_i,
  output dlfc_pkg::in_xfer_t xfer_o
);

  logic               valid_q, valid_d;
  dlfc_pkg::in_item_t data_q, data_d;

  assign in_stall_o = valid_q && full_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (!in_stall_o) begin
      valid_d = in_valid_i;
      data_d  = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign xfer_o.valid = valid_q && !full_i;
  assign xfer_o.data  = data_q;

endmodule

>>> design/dlfc_frame.sv
// frame parser: header, block crc checks, user octets and the end result
module dlfc_frame (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [7:0]          cfg_data_i,
  input  dlfc_pkg::in_xfer_t  xfer_i,
  output dlfc_pkg::out_xfer_t xfer_o
);

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_DATA   = 5'b00010,
    PH_CRC_LO = 5'b00100,
    PH_CRC_HI = 5'b01000,
    PH_SKIP   = 5'b10000
  } phase_e;

  phase_e                        phase_q, phase_d;
  logic [3:0]                    pos_q, pos_d;
  logic [dlfc_pkg::FILL_W-1:0]   fill_q, fill_d;
  logic [7:0]                    rem_q, rem_d;
  logic [15:0]                   crc_q, crc_d;
  logic [7:0]                    crc_lo_q, crc_lo_d;
  logic [7:0]                    len_q, len_d;
  logic [7:0]                    ctrl_q, ctrl_d;
  logic [15:0]                   dest_q, dest_d;
  logic [15:0]                   src_q, src_d;
  logic [7:0]                    cap_q;

  logic [7:0]  b;
  logic        last;
  logic [15:0] crc_base;
  logic [15:0] rx_crc;
  logic [7:0]  ulen;
  logic        ended;
  logic        end_push;
  dlfc_pkg::status_e end_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= dlfc_pkg::CAP_RESET;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  assign b        = xfer_i.data.rx_byte;
  assign last     = xfer_i.data.buffer_end;
  assign rx_crc   = {b, crc_lo_q};
  assign crc_base = (pos_q == 4'd0) ? 16'h0000 : crc_q;
  assign ulen     = len_q - dlfc_pkg::MIN_LEN;

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    fill_d     = fill_q;
    rem_d      = rem_q;
    crc_d      = crc_q;
    crc_lo_d   = crc_lo_q;
    len_d      = len_q;
    ctrl_d     = ctrl_q;
    dest_d     = dest_q;
    src_d      = src_q;
    ended      = 1'b0;
    end_push   = 1'b0;
    end_status = dlfc_pkg::ST_OK;
    xfer_o     = '0;

    if (xfer_i.valid) begin
      unique case (phase_q)
        PH_HEADER: begin
          if (pos_q == 4'd0) begin
            len_d  = '0;
            ctrl_d = '0;
            dest_d = '0;
            src_d  = '0;
          end
          if (pos_q <= 4'd7) begin
            crc_d = dlfc_pkg::crc_feed(crc_base, b);
          end
          unique case (pos_q)
            4'd2:    len_d         = b;
            4'd3:    ctrl_d        = b;
            4'd4:    dest_d[7:0]   = b;
            4'd5:    dest_d[15:8]  = b;
            4'd6:    src_d[7:0]    = b;
            4'd7:    src_d[15:8]   = b;
            default: ;
          endcase
          priority if ((pos_q == 4'd0 && b != dlfc_pkg::START_LO) ||
                       (pos_q == 4'd1 && b != dlfc_pkg::START_HI)) begin
            ended      = 1'b1;
            end_status = dlfc_pkg::ST_BAD_START;
          end else if (pos_q == 4'd2 && b < dlfc_pkg::MIN_LEN) begin
            ended      = 1'b1;
            end_status = dlfc_pkg::ST_SHORT_LEN;
          end else if (pos_q == 4'd8) begin
            crc_lo_d = b;
          end else if (pos_q >= 4'd9) begin
            priority if (rx_crc != (crc_q ^ dlfc_pkg::CRC_XOROUT)) begin
              ended      = 1'b1;
              end_status = dlfc_pkg::ST_HEADER_CRC;
            end else if (ulen > 8'(dlfc_pkg::MAX_USER_BYTES) || ulen > cap_q) begin
              ended      = 1'b1;
              end_status = dlfc_pkg::ST_CAPACITY;
            end else if (ulen == 8'd0) begin
              ended      = 1'b1;
              end_status = dlfc_pkg::ST_OK;
            end else begin
              phase_d = PH_DATA;
              rem_d   = ulen;
              fill_d  = '0;
              crc_d   = '0;
            end
          end else begin
          end
          pos_d = pos_q + 4'd1;
        end
        PH_DATA: begin
          crc_d  = dlfc_pkg::crc_feed(crc_q, b);
          fill_d = fill_q + dlfc_pkg::FILL_W'(1);
          if (rem_q != 8'd0) begin
            rem_d = rem_q - 8'd1;
          end
          xfer_o.push           = 1'b1;
          xfer_o.data.kind      = dlfc_pkg::KIND_USER;
          xfer_o.data.user_byte = b;
          if (fill_d >= dlfc_pkg::FILL_W'(dlfc_pkg::BLOCK_BYTES) || rem_d == 8'd0) begin
            phase_d = PH_CRC_LO;
          end
        end
        PH_CRC_LO: begin
          crc_lo_d = b;
          phase_d  = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          priority if (rx_crc != (crc_q ^ dlfc_pkg::CRC_XOROUT)) begin
            ended      = 1'b1;
            end_status = dlfc_pkg::ST_BLOCK_CRC;
          end else if (rem_q == 8'd0) begin
            ended      = 1'b1;
            end_status = dlfc_pkg::ST_OK;
          end else begin
            phase_d = PH_DATA;
            fill_d  = '0;
            crc_d   = '0;
          end
        end
        PH_SKIP: ;
        default: ;
      endcase

      if (phase_q != PH_SKIP) begin
        if (ended) begin
          end_push = 1'b1;
        end else if (last) begin
          // buffer ran out mid frame: replaces any user octet
          end_push   = 1'b1;
          end_status = dlfc_pkg::ST_TRUNCATED;
        end
        if (!last && end_push) begin
          phase_d = PH_SKIP;
        end
      end
      if (last) begin
        phase_d = PH_HEADER;
        pos_d   = 4'd0;
      end

      if (end_push) begin
        xfer_o.push               = 1'b1;
        xfer_o.data               = '0;
        xfer_o.data.kind          = dlfc_pkg::KIND_END;
        xfer_o.data.status        = end_status;
        xfer_o.data.control_octet = ctrl_d;
        xfer_o.data.destination   = dest_d;
        xfer_o.data.source        = src_d;
        xfer_o.data.length_octet  = len_d;
        xfer_o.data.user_count    = (len_d >= dlfc_pkg::MIN_LEN) ?
                                    (len_d - dlfc_pkg::MIN_LEN) : 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      pos_q    <= '0;
      fill_q   <= '0;
      rem_q    <= '0;
      crc_q    <= '0;
      crc_lo_q <= '0;
      len_q    <= '0;
      ctrl_q   <= '0;
      dest_q   <= '0;
      src_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      fill_q   <= fill_d;
      rem_q    <= rem_d;
      crc_q    <= crc_d;
      crc_lo_q <= crc_lo_d;
      len_q    <= len_d;
      ctrl_q   <= ctrl_d;
      dest_q   <= dest_d;
      src_q    <= src_d;
    end
  end

endmodule

>>> design/dlfc_out_fifo.sv
// two-entry result queue that decouples the parser from a stalling receiver
module dlfc_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dlfc_pkg::out_xfer_t xfer_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dlfc_pkg::out_item_t out_data_o
);

  dlfc_pkg::out_item_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign full_o      = (count_q == 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (xfer_i.push) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop) begin
      rd_ptr_d = !rd_ptr_q;
    end
    unique case ({xfer_i.push, pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (xfer_i.push) begin
      mem_q[wr_ptr_q] <= xfer_i.data;
    end
  end

endmodule

>>> design/dnp3_link_frame_checker_top.sv
// top level of the dnp3 link frame checker
//
// in channel: one octet of a buffered link frame per item, with buffer_end
// marking the last octet of the buffer. items are taken on in_valid_i high
// and in_stall_o low.
// out channel: one item per user octet (kind user) and exactly one frame end
// item per frame (kind end) with status and header fields. on any status
// other than ok the receiver drops the user octets already delivered.
// octets after an end item are ignored up to the buffer end.
// cfg channel: writes user_capacity, always ready; write only while idle.
// a result passes through the input register, then the result queue, before
// it is presented and can be taken.
// throughput: one octet per cycle while the result queue is not full, set by
// the byte-wide crc update in the parser.
// when the receiver stalls, the two-entry result queue fills and then the
// input register holds its octet and raises in_stall_o.
// reset: parser waits for the first octet of a frame, capacity returns to
// 250, queue and input register are emptied.
module dnp3_link_frame_checker_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dlfc_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dlfc_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_data_i
);

  dlfc_pkg::in_xfer_t  in_xfer;
  dlfc_pkg::out_xfer_t out_xfer;
  logic                full;

  assign cfg_ready_o = 1'b1;

  dlfc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .full_i     (full),
    .xfer_o     (in_xfer)
  );

  dlfc_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .xfer_i      (in_xfer),
    .xfer_o      (out_xfer)
  );

  dlfc_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .xfer_i      (out_xfer),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> design/dlfc_checker.sv
// port-level checks on the dnp3 link frame checker, bound to the top level
module dlfc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input dlfc_pkg::out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result item dropped or changed");

  // user items carry nothing but the octet
  a_user_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == dlfc_pkg::KIND_USER |->
      out_data_o.status == dlfc_pkg::ST_OK && out_data_o.length_octet == 8'd0 &&
      out_data_o.destination == 16'd0 && out_data_o.source == 16'd0 &&
      out_data_o.control_octet == 8'd0 && out_data_o.user_count == 8'd0)
    else $error("user item with header fields set");

  a_ok_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == dlfc_pkg::KIND_END &&
    out_data_o.status == dlfc_pkg::ST_OK |->
      out_data_o.length_octet >= dlfc_pkg::MIN_LEN &&
      out_data_o.user_count == out_data_o.length_octet - dlfc_pkg::MIN_LEN &&
      out_data_o.user_count <= 8'(dlfc_pkg::MAX_USER_BYTES))
    else $error("ok end item with inconsistent length");

  a_end_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == dlfc_pkg::KIND_END |->
      out_data_o.user_byte == 8'd0)
    else $error("end item with user octet set");

endmodule

bind dnp3_link_frame_checker_top dlfc_checker u_dlfc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

>>> sim/dnp3_link_frame_checker_top_tb.sv
// testbench for the dnp3 link frame checker top level, with a frame parser predictor
module dnp3_link_frame_checker_top_tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_GAP     = 12;
  localparam int unsigned MAX_REPORTS = 200;

  typedef enum logic [2:0] {
    P_HEADER,
    P_DATA,
    P_CRC_LO,
    P_CRC_HI,
    P_SKIP
  } parse_phase_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  dlfc_pkg::in_item_t  in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  dlfc_pkg::out_item_t out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [7:0]          cfg_data_i  = '0;

  dnp3_link_frame_checker_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  int unsigned cycle_count   = 0;
  int unsigned error_count   = 0;
  int unsigned octets_sent   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;

  dlfc_pkg::out_item_t pending_results[$];
  logic [7:0]          frame_octets[$];

  // parser predictor state
  parse_phase_e ph        = P_HEADER;
  logic [8:0]   pos       = '0;
  int unsigned  fill      = 0;
  logic [7:0]   remaining = '0;
  logic [15:0]  crc_acc   = '0;
  logic [7:0]   crc_lo    = '0;
  logic [47:0]  hdr       = '0;
  logic [7:0]   cap_model = dlfc_pkg::CAP_RESET;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (error_count < MAX_REPORTS)
      $display("mismatch %s: got %0h want %0h", what, got, want);
    error_count++;
  endtask

  always @(posedge clk_i) begin : result_check
    dlfc_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", {7'd0, out_data_o.kind, out_data_o.user_byte}, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.kind !== want.kind)
          report_mismatch("kind", out_data_o.kind, want.kind);
        if (out_data_o.user_byte !== want.user_byte)
          report_mismatch("user_byte", out_data_o.user_byte, want.user_byte);
        if (out_data_o.status !== want.status)
          report_mismatch("status", out_data_o.status, want.status);
        if (out_data_o.control_octet !== want.control_octet)
          report_mismatch("control_octet", out_data_o.control_octet, want.control_octet);
        if (out_data_o.destination !== want.destination)
          report_mismatch("destination", out_data_o.destination, want.destination);
        if (out_data_o.source !== want.source)
          report_mismatch("source", out_data_o.source, want.source);
        if (out_data_o.length_octet !== want.length_octet)
          report_mismatch("length_octet", out_data_o.length_octet, want.length_octet);
        if (out_data_o.user_count !== want.user_count)
          report_mismatch("user_count", out_data_o.user_count, want.user_count);
      end
    end
  end

  // bit-serial form of the reflected crc-16/dnp update
  function automatic logic [15:0] dnp_crc_octet(logic [15:0] crc, logic [7:0] b);
    logic [15:0] r;
    r = crc;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ b[i])
        r = (r >> 1) ^ dlfc_pkg::CRC_POLY;
      else
        r = r >> 1;
    end
    return r;
  endfunction

  function automatic dlfc_pkg::out_item_t frame_end_item(dlfc_pkg::status_e st);
    dlfc_pkg::out_item_t r;
    r = '0;
    r.kind          = dlfc_pkg::KIND_END;
    r.status        = st;
    r.control_octet = hdr[15:8];
    r.destination   = hdr[31:16];
    r.source        = hdr[47:32];
    r.length_octet  = hdr[7:0];
    r.user_count    = (hdr[7:0] >= dlfc_pkg::MIN_LEN) ? hdr[7:0] - dlfc_pkg::MIN_LEN : 8'd0;
    return r;
  endfunction

  task automatic predict_octet(input logic [7:0] b, input logic last);
    logic                has_end;
    logic                has_user;
    dlfc_pkg::status_e   st;
    logic [7:0]          ulen;
    dlfc_pkg::out_item_t u;
    has_end  = 1'b0;
    has_user = 1'b0;
    st       = dlfc_pkg::ST_OK;
    if (ph == P_SKIP) begin
      // trailing octets after an end item give nothing
      if (last) begin
        ph  = P_HEADER;
        pos = '0;
      end
      return;
    end
    case (ph)
      P_HEADER: begin
        if (pos == 0) begin
          hdr     = '0;
          crc_acc = '0;
        end
        if (pos <= 7) begin
          if (pos >= 2) hdr[(int'(pos) - 2) * 8 +: 8] = b;
          crc_acc = dnp_crc_octet(crc_acc, b);
        end
        if ((pos == 0 && b != dlfc_pkg::START_LO) ||
            (pos == 1 && b != dlfc_pkg::START_HI)) begin
          has_end = 1'b1;
          st      = dlfc_pkg::ST_BAD_START;
        end else if (pos == 2 && b < dlfc_pkg::MIN_LEN) begin
          has_end = 1'b1;
          st      = dlfc_pkg::ST_SHORT_LEN;
        end else if (pos == 8) begin
          crc_lo = b;
        end else if (pos >= 9) begin
          ulen = hdr[7:0] - dlfc_pkg::MIN_LEN;
          if ({b, crc_lo} != (crc_acc ^ dlfc_pkg::CRC_XOROUT)) begin
            has_end = 1'b1;
            st      = dlfc_pkg::ST_HEADER_CRC;
          end else if (ulen > dlfc_pkg::MAX_USER_BYTES || ulen > cap_model) begin
            has_end = 1'b1;
            st      = dlfc_pkg::ST_CAPACITY;
          end else if (ulen == 0) begin
            has_end = 1'b1;
            st      = dlfc_pkg::ST_OK;
          end else begin
            ph        = P_DATA;
            remaining = ulen;
            fill      = 0;
            crc_acc   = '0;
          end
        end
        pos = pos + 9'd1;
      end
      P_DATA: begin
        crc_acc = dnp_crc_octet(crc_acc, b);
        fill++;
        if (remaining > 0) remaining--;
        has_user = 1'b1;
        if (fill >= dlfc_pkg::BLOCK_BYTES || remaining == 0) ph = P_CRC_LO;
      end
      P_CRC_LO: begin
        crc_lo = b;
        ph     = P_CRC_HI;
      end
      default: begin
        if ({b, crc_lo} != (crc_acc ^ dlfc_pkg::CRC_XOROUT)) begin
          has_end = 1'b1;
          st      = dlfc_pkg::ST_BLOCK_CRC;
        end else if (remaining == 0) begin
          has_end = 1'b1;
          st      = dlfc_pkg::ST_OK;
        end else begin
          ph      = P_DATA;
          fill    = 0;
          crc_acc = '0;
        end
      end
    endcase
    // a buffer end that settles nothing reports truncation instead of the user octet
    if (!has_end && last) begin
      has_end = 1'b1;
      st      = dlfc_pkg::ST_TRUNCATED;
    end
    if (has_end) begin
      pending_results.push_back(frame_end_item(st));
    end else if (has_user) begin
      u           = '0;
      u.kind      = dlfc_pkg::KIND_USER;
      u.user_byte = b;
      pending_results.push_back(u);
    end
    if (last) begin
      ph  = P_HEADER;
      pos = '0;
    end else if (has_end) begin
      ph = P_SKIP;
    end
  endtask

  task automatic send_octet(input logic [7:0] b, input logic last);
    int unsigned        gap;
    dlfc_pkg::in_item_t item;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item.rx_byte    = b;
    item.buffer_end = last;
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_octet(b, last);
    octets_sent++;
  endtask

  task automatic send_buffer();
    for (int i = 0; i < frame_octets.size(); i++)
      send_octet(frame_octets[i], i == frame_octets.size() - 1);
  endtask

  // correct frame: header, header crc, user blocks each with its crc
  task automatic build_frame(input logic [7:0] len, input logic [7:0] ctrl,
                             input logic [15:0] dst, input logic [15:0] src);
    logic [15:0] c;
    int          ulen;
    int          k;
    logic [7:0]  d;
    frame_octets.delete();
    frame_octets.push_back(dlfc_pkg::START_LO);
    frame_octets.push_back(dlfc_pkg::START_HI);
    frame_octets.push_back(len);
    frame_octets.push_back(ctrl);
    frame_octets.push_back(dst[7:0]);
    frame_octets.push_back(dst[15:8]);
    frame_octets.push_back(src[7:0]);
    frame_octets.push_back(src[15:8]);
    c = '0;
    for (int i = 0; i < 8; i++) c = dnp_crc_octet(c, frame_octets[i]);
    c = c ^ dlfc_pkg::CRC_XOROUT;
    frame_octets.push_back(c[7:0]);
    frame_octets.push_back(c[15:8]);
    ulen = (len >= dlfc_pkg::MIN_LEN) ? int'(len) - int'(dlfc_pkg::MIN_LEN) : 0;
    k = 0;
    c = '0;
    for (int i = 0; i < ulen; i++) begin
      d = $urandom_range(0, 255);
      frame_octets.push_back(d);
      c = dnp_crc_octet(c, d);
      k++;
      if (k == dlfc_pkg::BLOCK_BYTES || i == ulen - 1) begin
        c = c ^ dlfc_pkg::CRC_XOROUT;
        frame_octets.push_back(c[7:0]);
        frame_octets.push_back(c[15:8]);
        c = '0;
        k = 0;
      end
    end
  endtask

  task automatic keep_first(input int n);
    while (frame_octets.size() > n) void'(frame_octets.pop_back());
  endtask

  task automatic append_noise(input int n);
    repeat (n) frame_octets.push_back($urandom_range(0, 255));
  endtask

  function automatic logic [7:0] rand_octet();
    return $urandom_range(0, 255);
  endfunction

  function automatic logic [15:0] rand_addr();
    return $urandom_range(0, 65535);
  endfunction

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    // octets that cause no item may still be in flight
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [7:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cap_model = v;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_start_octets();
    build_frame(8'd7, rand_octet(), rand_addr(), rand_addr());
    frame_octets[0] = 8'h00;
    send_buffer();
    build_frame(8'd7, rand_octet(), rand_addr(), rand_addr());
    frame_octets[1] = 8'h46;
    send_buffer();
    // lone first start octet marked as buffer end
    frame_octets.delete();
    frame_octets.push_back(dlfc_pkg::START_LO);
    send_buffer();
  endtask

  task automatic test_length_field();
    build_frame(8'd5, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_buffer();
    build_frame(8'd5, 8'h00, 16'h0000, 16'h0000);
    send_buffer();
    build_frame(8'd4, rand_octet(), rand_addr(), rand_addr());
    send_buffer();
    build_frame(8'd0, rand_octet(), rand_addr(), rand_addr());
    send_buffer();
    build_frame(8'd255, rand_octet(), rand_addr(), rand_addr());
    send_buffer();
  endtask

  task automatic test_header_crc();
    build_frame(8'd10, rand_octet(), rand_addr(), rand_addr());
    frame_octets[9] = frame_octets[9] ^ 8'h80;
    send_buffer();
    build_frame(8'd10, rand_octet(), rand_addr(), rand_addr());
    frame_octets[8] = frame_octets[8] ^ 8'h01;
    send_buffer();
    build_frame(8'd10, rand_octet(), rand_addr(), rand_addr());
    frame_octets[5] = frame_octets[5] ^ 8'h10;
    send_buffer();
  endtask

  task automatic test_capacity();
    drain_results();
    write_capacity(8'd0);
    build_frame(8'd6, rand_octet(), rand_addr(), rand_addr());
    send_buffer();
    build_frame(8'd5, rand_octet(), rand_addr(), rand_addr());
    send_buffer();
    drain_results();
    write_capacity(8'd255);
    build_frame(8'd60, rand_octet(), rand_addr(), rand_addr());
    send_buffer();
    drain_results();
    write_capacity(8'd16);
    build_frame(8'd21, rand_octet(), rand_addr(), rand_addr());
    send_buffer();
    build_frame(8'd22, rand_octet(), rand_addr(), rand_addr());
    send_buffer();
    drain_results();
    write_capacity(dlfc_pkg::CAP_RESET);
  endtask

  task automatic test_block_crc();
    build_frame(8'd21, rand_octet(), rand_addr(), rand_addr());
    send_buffer();
    build_frame(8'd22, rand_octet(), rand_addr(), rand_addr());
    send_buffer();
    // bad octet inside the second block
    build_frame(8'd40, rand_octet(), rand_addr(), rand_addr());
    frame_octets[30] = frame_octets[30] ^ 8'h04;
    send_buffer();
    build_frame(8'd40, rand_octet(), rand_addr(), rand_addr());
    frame_octets[27] = frame_octets[27] ^ 8'h40;
    send_buffer();
  endtask

  task automatic test_truncation();
    int cuts[4] = '{9, 15, 27, 28};
    foreach (cuts[i]) begin
      build_frame(8'd40, rand_octet(), rand_addr(), rand_addr());
      keep_first(cuts[i]);
      send_buffer();
    end
  endtask

  task automatic test_trailing_octets();
    build_frame(8'd8, rand_octet(), rand_addr(), rand_addr());
    append_noise(3);
    send_buffer();
    build_frame(8'd7, rand_octet(), rand_addr(), rand_addr());
    frame_octets[2] = 8'd3;
    send_buffer();
    build_frame(8'd5, rand_octet(), rand_addr(), rand_addr());
    append_noise(10);
    send_buffer();
  endtask

  task automatic random_buffer();
    int unsigned sel;
    int unsigned ulen;
    int unsigned idx;
    ulen = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 250) : $urandom_range(0, 40);
    build_frame(8'(ulen + 5), rand_octet(), rand_addr(), rand_addr());
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      // clean frame
    end else if (sel < 70) begin
      idx = $urandom_range(0, frame_octets.size() - 1);
      frame_octets[idx] = frame_octets[idx] ^ (8'h01 << $urandom_range(0, 7));
    end else if (sel < 80) begin
      keep_first($urandom_range(1, frame_octets.size() - 1));
    end else if (sel < 85) begin
      frame_octets[2] = $urandom_range(0, 4);
    end else if (sel < 90) begin
      frame_octets.delete();
      append_noise($urandom_range(1, 12));
    end else begin
      append_noise($urandom_range(1, 5));
    end
    send_buffer();
  endtask

  task automatic test_random_traffic(input logic [7:0] cap, input int unsigned idle_pct,
                                     input int unsigned stall_in_pct, input int unsigned n);
    int unsigned stop_at;
    drain_results();
    write_capacity(cap);
    send_idle_pct = idle_pct;
    stall_pct     = stall_in_pct;
    stop_at = octets_sent + n;
    while (octets_sent < stop_at) random_buffer();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_start_octets();
    test_length_field();
    test_header_crc();
    test_capacity();
    test_block_crc();
    test_truncation();
    test_trailing_octets();
    test_random_traffic(8'd250, 0, 0, 40);
    test_random_traffic(8'd255, 67, 0, 40);
    test_random_traffic(8'd12, 0, 67, 40);
    test_random_traffic(8'($urandom_range(0, 255)), 16, 16, 40);
    drain_results();
    if (pending_results.size() != 0)
      report_mismatch("items never seen", 16'(pending_results.size()), '0);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
